FILE: sv/fac_pkg.sv
`timescale 1ns / 1ps
// fac_pkg: shared types and constants of the fall alarm confirmation block
// used by the channel interfaces and by fall_alarm_confirm_fsm; no dependencies
package fac_pkg;

	localparam int TICK_W     = 32;
	localparam int CNT_W      = 32;
	localparam int COOLDOWN_W = 16;
	localparam int CONFIRM_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// elapsed ticks are scaled by the number of milliseconds in a second
	localparam int MS_PER_SECOND = 1000;
	localparam int MS_SCALE_W    = 10;
	localparam int SCALED_W      = TICK_W + MS_SCALE_W;

	localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 16'd5000;
	localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET  = 4'd3;
	localparam logic [CONFIRM_W-1:0]  RUN_MAX        = 4'd15;

	typedef enum logic [2:0] {
		PH_NORMAL    = 3'd0,
		PH_FALLING   = 3'd1,
		PH_CONFIRMED = 3'd2,
		PH_COOLDOWN  = 3'd3,
		PH_RESET     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_CONFIRMED = 2'd1,
		EV_CLEARED   = 2'd2,
		EV_NO_PERSON = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_MS        = 1'b0,
		CFG_CONFIRM_FRAMES = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		MODE_FRAME = 1'b0,
		MODE_RESET = 1'b1
	} mode_t;

	typedef struct packed {
		logic              mode;
		logic              person_present;
		logic              falling;
		logic [TICK_W-1:0] tick_now;
		logic [TICK_W-1:0] frame_number;
	} frame_item_t;

endpackage

FILE: sv/fac_if.sv
`timescale 1ns / 1ps
// fac_in_if / fac_out_if: valid/ready channels for frame items and alarm results
// depends on fac_pkg for field widths
interface fac_in_if import fac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic              person_present;
	logic              falling;
	logic [TICK_W-1:0] tick_now;
	logic [TICK_W-1:0] frame_number;

	modport source(output valid, output mode, output person_present, output falling,
		output tick_now, output frame_number, input ready);
	modport sink(input valid, input mode, input person_present, input falling,
		input tick_now, input frame_number, output ready);
endinterface

interface fac_out_if import fac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        event_res;
	logic [2:0]        alarm_state;
	logic [TICK_W-1:0] event_frame;
	logic [TICK_W-1:0] event_tick;
	logic [CNT_W-1:0]  frames_seen;
	logic [CNT_W-1:0]  falls_confirmed;
	logic [CNT_W-1:0]  false_alarms;

	modport source(output valid, output event_res, output alarm_state, output event_frame,
		output event_tick, output frames_seen, output falls_confirmed,
		output false_alarms, input ready);
	modport sink(input valid, input event_res, input alarm_state, input event_frame,
		input event_tick, input frames_seen, input falls_confirmed,
		input false_alarms, output ready);
endinterface

FILE: sv/fall_alarm_confirm_fsm.sv
`timescale 1ns / 1ps
// fall_alarm_confirm_fsm: per-frame fall alarm state machine with wrapping counters
// depends on fac_pkg and the channel interfaces in fac_if.sv
// an accepted item passes from the input register through the update to the result register;
//   throughput one item per cycle while alarms.ready stays high, set by the single update stage
// an input register and a result register part the two channels; while a finished
//   result waits for the consumer, one more item is still taken into the input register
// reset (arst_n low): phase normal, counters and run cleared, cooldown 5000 ms,
//   three confirm frames, both pipeline stages empty
module fall_alarm_confirm_fsm import fac_pkg::*; #(
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fac_in_if.sink                frames,
	fac_out_if.source             alarms
);

	// threshold is the hold period in ms times TICKS_PER_SECOND, kept premultiplied
	// so the timer test is just a scaled subtract and a compare
	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int RHS_W  = COOLDOWN_W + TPS_W;
	localparam int CMP_W  = (SCALED_W > RHS_W) ? SCALED_W : RHS_W;

	// configuration
	logic [RHS_W-1:0]     threshold_q;
	logic [CONFIRM_W-1:0] confirm_frames_q;

	// input stage
	logic        in_valid_s1;
	frame_item_t item_s1;

	// alarm state
	phase_t               phase_q, phase_d;
	logic [CONFIRM_W-1:0] run_q, run_d;
	logic [TICK_W-1:0]    start_tick_q, start_tick_d;
	logic [CNT_W-1:0]     frame_total_q, frame_total_d;
	logic [CNT_W-1:0]     fall_total_q, fall_total_d;
	logic [CNT_W-1:0]     false_total_q, false_total_d;
	event_t               ev_d;

	// result register
	logic                 out_valid_q;
	event_t               ev_q;
	logic [TICK_W-1:0]    event_frame_q;
	logic [TICK_W-1:0]    event_tick_q;

	logic                 advance;
	logic                 step;
	logic [TICK_W-1:0]    elapsed;
	logic [CMP_W-1:0]     elapsed_scaled;
	logic                 period_over;
	logic [CONFIRM_W-1:0] run_inc;
	logic                 run_reached;

	// handshake: the result register frees whenever it is empty or being taken
	assign advance      = !out_valid_q || alarms.ready;
	assign frames.ready = !in_valid_s1 || advance;
	assign step         = in_valid_s1 && advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= RHS_W'(COOLDOWN_RESET) * RHS_W'(TICKS_PER_SECOND);
			confirm_frames_q <= CONFIRM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HOLD_MS: begin
					threshold_q <= RHS_W'(cfg_wdata[COOLDOWN_W-1:0]) * RHS_W'(TICKS_PER_SECOND);
				end
				CFG_CONFIRM_FRAMES: begin
					confirm_frames_q <= cfg_wdata[CONFIRM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			in_valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			item_s1.mode           <= frames.mode;
			item_s1.person_present <= frames.person_present;
			item_s1.falling        <= frames.falling;
			item_s1.tick_now       <= frames.tick_now;
			item_s1.frame_number   <= frames.frame_number;
		end
	end

	// timer: elapsed ticks wrap modulo 2^32, then scale to compare against ms * tps
	assign elapsed        = item_s1.tick_now - start_tick_q;
	assign elapsed_scaled = CMP_W'(elapsed) * CMP_W'(MS_PER_SECOND);
	assign period_over    = elapsed_scaled >= CMP_W'(threshold_q);

	// falling run saturates at its maximum
	assign run_inc     = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
	assign run_reached = run_inc >= confirm_frames_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		priority if (item_s1.mode == MODE_RESET) begin
			phase_d = PH_RESET;
		end else if (!item_s1.person_present) begin
			// an open falling run is dropped without a false alarm, other phases hold
			if (phase_q == PH_FALLING) begin
				phase_d = PH_NORMAL;
			end
		end else begin
			unique case (phase_q)
				PH_NORMAL: begin
					if (item_s1.falling) begin
						phase_d = PH_FALLING;
					end
				end
				PH_FALLING: begin
					if (!item_s1.falling) begin
						phase_d = PH_NORMAL;
					end else if (run_reached) begin
						phase_d = PH_CONFIRMED;
					end
				end
				PH_CONFIRMED: begin
					if (period_over) begin
						phase_d = PH_COOLDOWN;
					end
				end
				PH_COOLDOWN: begin
					if (period_over) begin
						phase_d = PH_NORMAL;
					end
				end
				default: begin
					// reset phase (and unused codes) go back to normal on a person
					phase_d = PH_NORMAL;
				end
			endcase
		end
	end

	// run, phase timer, counters and event
	always_comb begin
		run_d         = run_q;
		start_tick_d  = start_tick_q;
		frame_total_d = frame_total_q;
		fall_total_d  = fall_total_q;
		false_total_d = false_total_q;
		ev_d          = EV_NONE;
		priority if (item_s1.mode == MODE_RESET) begin
			// reset command counts nothing
			run_d = '0;
		end else begin
			frame_total_d = frame_total_q + 1'b1;
			if (!item_s1.person_present) begin
				if (phase_q == PH_FALLING) begin
					run_d = '0;
				end
				ev_d = EV_NO_PERSON;
			end else begin
				unique case (phase_q)
					PH_NORMAL: begin
						if (item_s1.falling) begin
							run_d        = CONFIRM_W'(1);
							start_tick_d = item_s1.tick_now;
						end
					end
					PH_FALLING: begin
						if (item_s1.falling) begin
							run_d = run_inc;
							if (run_reached) begin
								start_tick_d = item_s1.tick_now;
								fall_total_d = fall_total_q + 1'b1;
								ev_d         = EV_CONFIRMED;
							end
						end else begin
							// broken run counts as a false alarm
							run_d         = '0;
							false_total_d = false_total_q + 1'b1;
						end
					end
					PH_CONFIRMED: begin
						if (period_over) begin
							start_tick_d = item_s1.tick_now;
						end
					end
					PH_COOLDOWN: begin
						if (period_over) begin
							run_d = '0;
							ev_d  = EV_CLEARED;
						end
					end
					default: begin
						run_d = '0;
					end
				endcase
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_NORMAL;
			run_q         <= '0;
			start_tick_q  <= '0;
			frame_total_q <= '0;
			fall_total_q  <= '0;
			false_total_q <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			run_q         <= run_d;
			start_tick_q  <= start_tick_d;
			frame_total_q <= frame_total_d;
			fall_total_q  <= fall_total_d;
			false_total_q <= false_total_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_q          <= ev_d;
			event_frame_q <= (ev_d == EV_CONFIRMED) ? item_s1.frame_number : '0;
			event_tick_q  <= (ev_d == EV_CONFIRMED) ? item_s1.tick_now : '0;
		end
	end

	// counters and phase already hold the post-step values of the item in the result register
	assign alarms.valid           = out_valid_q;
	assign alarms.event_res       = ev_q;
	assign alarms.alarm_state     = phase_q;
	assign alarms.event_frame     = event_frame_q;
	assign alarms.event_tick      = event_tick_q;
	assign alarms.frames_seen     = frame_total_q;
	assign alarms.falls_confirmed = fall_total_q;
	assign alarms.false_alarms    = false_total_q;

endmodule
